FILE: sv/lva_pkg.sv
// ----------------------------------------------------------------------------
// lva_pkg
// Shared types and constants of the layered voice allocator: the voice
// table entry, the result record and the voice table port bundles.
// ----------------------------------------------------------------------------
package lva_pkg;

  // Fixed layer split of the voice table.
  localparam int LAYER_COUNT = 3;

  // Field widths.
  localparam int ACTION_W  = 2;
  localparam int CHANNEL_W = 4;
  localparam int KEY_W     = 7;
  localparam int TAG_W     = 32;
  localparam int LAYER_W   = 3;
  localparam int VID_W     = 6;
  localparam int KIND_W    = 2;
  localparam int STEP_W    = 16;
  localparam int LEVEL_W   = 17;

  // Full level in Q2.15.
  localparam logic [LEVEL_W-1:0] FULL_LEVEL = LEVEL_W'(32768);
  localparam logic [STEP_W-1:0]  RELEASE_STEP_RST = STEP_W'(5);

  // Voice modes.
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_ON   = 2'd1;
  localparam logic [1:0] MODE_REL  = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_MIDI_LAYER   = 1'b0;
  localparam logic CFG_RELEASE_STEP = 1'b1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NOTE_ON  = 2'd0,
    ACT_NOTE_OFF = 2'd1,
    ACT_TICK     = 2'd2,
    ACT_DONE     = 2'd3
  } action_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_DROP    = 2'd1,
    KIND_OFF     = 2'd2,
    KIND_TERM    = 2'd3
  } kind_e;

  // One voice table entry.
  typedef struct packed {
    logic [1:0]           mode;
    logic [CHANNEL_W-1:0] channel;
    logic [KEY_W-1:0]     key;
    logic [TAG_W-1:0]     tag;
    logic [LEVEL_W-1:0]   level;
  } voice_t;

  // One result record.
  typedef struct packed {
    kind_e                kind;
    logic [VID_W-1:0]     vid;
    logic [KEY_W-1:0]     key;
    logic [CHANNEL_W-1:0] channel;
    logic [TAG_W-1:0]     tag;
  } result_t;

  // Configuration values seen by the engine.
  typedef struct packed {
    logic              midi_ref;
    logic [STEP_W-1:0] rel_step;
  } cfg_t;

  // Voice table access from the engine.
  typedef struct packed {
    logic             rd_en;
    logic [VID_W-1:0] rd_addr;
    logic             wr_en;
    logic [VID_W-1:0] wr_addr;
    voice_t           wr_data;
  } ram_req_t;

  // Registered read data of the voice table.
  typedef struct packed {
    logic   vld;
    voice_t data;
  } ram_rsp_t;

endpackage

FILE: sv/lva_req_if.sv
// ----------------------------------------------------------------------------
// lva_req_if
// Request channel of the voice allocator: one note, tick or done event.
// ----------------------------------------------------------------------------
interface lva_req_if
  import lva_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [ACTION_W-1:0]       action;
  logic [CHANNEL_W-1:0]      channel;
  logic [KEY_W-1:0]          key;
  logic signed [TAG_W-1:0]   tag;
  logic signed [LAYER_W-1:0] layer_sel;
  logic [VID_W-1:0]          voice_index;

  modport source (
    output valid, action, channel, key, tag, layer_sel, voice_index,
    input  ready
  );

  modport sink (
    input  valid, action, channel, key, tag, layer_sel, voice_index,
    output ready
  );
endinterface

FILE: sv/lva_rsp_if.sv
// ----------------------------------------------------------------------------
// lva_rsp_if
// Result channel of the voice allocator: one allocation, drop, note-off or
// termination report.
// ----------------------------------------------------------------------------
interface lva_rsp_if
  import lva_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       kind;
  logic [VID_W-1:0]        voice_id;
  logic [KEY_W-1:0]        out_key;
  logic [CHANNEL_W-1:0]    out_channel;
  logic signed [TAG_W-1:0] out_tag;
  logic                    last;

  modport source (
    output valid, kind, voice_id, out_key, out_channel, out_tag, last,
    input  ready
  );

  modport sink (
    input  valid, kind, voice_id, out_key, out_channel, out_tag, last,
    output ready
  );
endinterface

FILE: sv/lva_voice_ram.sv
// ----------------------------------------------------------------------------
// lva_voice_ram
// Voice table: one write port and one read port with registered read data.
// A valid bit per entry makes unwritten entries read as idle after reset.
// ----------------------------------------------------------------------------
module lva_voice_ram
  import lva_pkg::*;
#(
  parameter int NumVoices = 48
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  ram_req_t req_i,
  output ram_rsp_t rsp_o
);

  localparam int IdxW = (NumVoices > 1) ? $clog2(NumVoices) : 1;

  voice_t               mem [NumVoices];
  logic [NumVoices-1:0] vld_q;
  voice_t               rd_data_q;
  logic                 rd_vld_q;

  // Storage array and read data register.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr[IdxW-1:0]] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr[IdxW-1:0]];
    end
  end

  // Entry valid bits, cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[req_i.wr_addr[IdxW-1:0]] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr[IdxW-1:0]];
      end
    end
  end

  assign rsp_o.vld  = rd_vld_q;
  assign rsp_o.data = rd_data_q;

endmodule

FILE: sv/lva_engine.sv
// ----------------------------------------------------------------------------
// lva_engine
// Scan sequencer of the voice allocator. It takes one request, walks the
// voice table through read, modify and write back, holds the latest result
// until the next one or the end of the scan shows whether it is the last,
// and drives the result register.
// ----------------------------------------------------------------------------
module lva_engine
  import lva_pkg::*;
#(
  parameter int NumVoices = 48
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  lva_req_if.sink   req,
  lva_rsp_if.source rsp,
  output ram_req_t  ram_req_o,
  input  ram_rsp_t  ram_rsp_i
);

  localparam int AddrW = $clog2(NumVoices + LAYER_COUNT);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  state_e               state_q, state_d;
  action_e              act_q, act_d;
  logic [CHANNEL_W-1:0] ch_q, ch_d;
  logic [KEY_W-1:0]     key_q, key_d;
  logic [TAG_W-1:0]     tag_q, tag_d;
  logic [1:0]           step_q, step_d;
  logic                 single_q, single_d;
  logic                 iss_q, iss_d;
  logic [AddrW-1:0]     rd_addr_q, rd_addr_d;
  logic                 p_vld_q, p_vld_d;
  logic [AddrW-1:0]     p_addr_q, p_addr_d;
  logic                 pend_vld_q, pend_vld_d;
  result_t              pend_q, pend_d;
  logic                 out_vld_q, out_vld_d;
  result_t              out_q, out_d;
  logic                 out_last_q, out_last_d;

  // Entry processing signals.
  voice_t               cur;
  logic [1:0]           cur_mode;
  logic                 hit;
  logic                 wr_need;
  voice_t               wr_entry;
  result_t              res;
  logic signed [LEVEL_W:0] lvl_next;

  // Request decode signals.
  logic                 lsel_any;
  logic                 lsel_ok;
  logic [1:0]           tgt_layer;
  logic [AddrW-1:0]     next_addr;
  logic                 can_push;
  logic                 stall;
  logic                 adv;
  logic                 push;
  result_t              push_res;
  logic                 push_last;

  // Modify step on the entry that the read pipeline delivers.
  always_comb begin
    cur      = ram_rsp_i.data;
    cur_mode = ram_rsp_i.vld ? cur.mode : MODE_IDLE;
    hit      = 1'b0;
    wr_need  = 1'b0;
    wr_entry = cur;
    res      = '{kind: KIND_TERM, vid: VID_W'(p_addr_q), key: cur.key,
                 channel: cur.channel, tag: cur.tag};
    lvl_next = $signed({1'b0, cur.level}) - $signed({2'b00, cfg_i.rel_step});
    unique case (act_q)
      ACT_NOTE_ON: begin
        if (cur_mode == MODE_IDLE) begin
          hit      = 1'b1;
          wr_need  = 1'b1;
          wr_entry = '{mode: MODE_ON, channel: ch_q, key: key_q, tag: tag_q,
                       level: FULL_LEVEL};
          res      = '{kind: KIND_ALLOC, vid: VID_W'(p_addr_q), key: '0,
                       channel: '0, tag: '0};
        end
      end
      ACT_NOTE_OFF: begin
        if (cur_mode == MODE_ON && cur.channel == ch_q && cur.key == key_q) begin
          wr_need       = 1'b1;
          wr_entry.mode = MODE_REL;
        end
      end
      ACT_TICK: begin
        if (cur_mode == MODE_REL) begin
          wr_need = 1'b1;
          if (lvl_next[LEVEL_W] || lvl_next == '0) begin
            hit           = 1'b1;
            wr_entry.mode = MODE_IDLE;
          end else begin
            wr_entry.level = lvl_next[LEVEL_W-1:0];
          end
        end
      end
      ACT_DONE: begin
        if (cur_mode != MODE_IDLE) begin
          hit           = 1'b1;
          wr_need       = 1'b1;
          wr_entry.mode = MODE_IDLE;
        end
      end
      default: ;
    endcase
  end

  // Layer select decode: minus one means default or any layer.
  assign lsel_any  = (req.layer_sel == -3'sd1);
  assign lsel_ok   = !req.layer_sel[LAYER_W-1] && (req.layer_sel[1:0] != 2'd3);
  assign tgt_layer = lsel_any ? (cfg_i.midi_ref ? 2'd2 : 2'd0) : req.layer_sel[1:0];

  assign next_addr = rd_addr_q + AddrW'(step_q);
  assign can_push  = !out_vld_q || rsp.ready;
  assign stall     = p_vld_q && hit && pend_vld_q && !can_push;
  assign adv       = !stall;

  assign req.ready = (state_q == S_IDLE);

  // Sequencer next state.
  always_comb begin
    state_d    = state_q;
    act_d      = act_q;
    ch_d       = ch_q;
    key_d      = key_q;
    tag_d      = tag_q;
    step_d     = step_q;
    single_d   = single_q;
    iss_d      = iss_q;
    rd_addr_d  = rd_addr_q;
    p_vld_d    = p_vld_q;
    p_addr_d   = p_addr_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    push       = 1'b0;
    push_res   = pend_q;
    push_last  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req.valid) begin
          state_d    = S_SCAN;
          act_d      = action_e'(req.action);
          ch_d       = req.channel;
          key_d      = req.key;
          tag_d      = req.tag;
          single_d   = 1'b0;
          step_d     = 2'd1;
          rd_addr_d  = '0;
          iss_d      = 1'b1;
          pend_vld_d = 1'b0;
          unique case (action_e'(req.action))
            ACT_NOTE_ON: begin
              step_d    = 2'(LAYER_COUNT);
              rd_addr_d = AddrW'(tgt_layer);
              iss_d     = lsel_any || lsel_ok;
            end
            ACT_NOTE_OFF: begin
              if (!lsel_any) begin
                step_d    = 2'(LAYER_COUNT);
                rd_addr_d = AddrW'(tgt_layer);
                iss_d     = lsel_ok;
              end
            end
            ACT_TICK: ;
            ACT_DONE: begin
              single_d  = 1'b1;
              rd_addr_d = AddrW'(req.voice_index);
              iss_d     = int'(req.voice_index) < NumVoices;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (adv) begin
          p_vld_d  = iss_q;
          p_addr_d = rd_addr_q;
          if (iss_q) begin
            rd_addr_d = next_addr;
            iss_d     = !single_q && (next_addr < AddrW'(NumVoices));
          end
          if (p_vld_q && hit) begin
            // An earlier held result is now known not to be the last.
            if (pend_vld_q) begin
              push = 1'b1;
            end
            pend_vld_d = 1'b1;
            pend_d     = res;
            // A note-on stops at the first free voice.
            if (act_q == ACT_NOTE_ON) begin
              iss_d   = 1'b0;
              p_vld_d = 1'b0;
            end
          end
        end
        // End of scan: report the closing result, if there is one.
        if (!iss_q && !p_vld_q && can_push) begin
          state_d    = S_IDLE;
          pend_vld_d = 1'b0;
          push_last  = 1'b1;
          if (pend_vld_q) begin
            push = 1'b1;
          end else if (act_q == ACT_NOTE_ON) begin
            push     = 1'b1;
            push_res = '{kind: KIND_DROP, vid: '0, key: '0, channel: '0, tag: '0};
          end else if (act_q == ACT_NOTE_OFF) begin
            push     = 1'b1;
            push_res = '{kind: KIND_OFF, vid: '0, key: '0, channel: '0, tag: '0};
          end
        end
      end
      default: ;
    endcase
  end

  // Result register.
  always_comb begin
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    out_last_d = out_last_q;
    if (push) begin
      out_vld_d  = 1'b1;
      out_d      = push_res;
      out_last_d = push_last;
    end else if (rsp.ready) begin
      out_vld_d = 1'b0;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      act_q      <= ACT_NOTE_ON;
      iss_q      <= 1'b0;
      p_vld_q    <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      act_q      <= act_d;
      iss_q      <= iss_d;
      p_vld_q    <= p_vld_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ch_q       <= ch_d;
    key_q      <= key_d;
    tag_q      <= tag_d;
    step_q     <= step_d;
    single_q   <= single_d;
    rd_addr_q  <= rd_addr_d;
    p_addr_q   <= p_addr_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  // Voice table access.
  assign ram_req_o.rd_en   = (state_q == S_SCAN) && iss_q && adv;
  assign ram_req_o.rd_addr = VID_W'(rd_addr_q);
  assign ram_req_o.wr_en   = (state_q == S_SCAN) && p_vld_q && wr_need && adv;
  assign ram_req_o.wr_addr = VID_W'(p_addr_q);
  assign ram_req_o.wr_data = wr_entry;

  // Result channel.
  assign rsp.valid       = out_vld_q;
  assign rsp.kind        = out_q.kind;
  assign rsp.voice_id    = out_q.vid;
  assign rsp.out_key     = out_q.key;
  assign rsp.out_channel = out_q.channel;
  assign rsp.out_tag     = out_q.tag;
  assign rsp.last        = out_last_q;

`ifndef NO_ASSERTIONS
  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !iss_q && !p_vld_q && !pend_vld_q)
    else $error("scan pipeline busy while idle");

  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req_o.rd_en |-> int'(ram_req_o.rd_addr) < NumVoices)
    else $error("voice table read beyond last voice");

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req_o.wr_en |-> int'(ram_req_o.wr_addr) < NumVoices)
    else $error("voice table write beyond last voice");

  a_stall_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |-> !ram_req_o.wr_en && !ram_req_o.rd_en)
    else $error("voice table access during result stall");

  a_scan_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN && state_d == S_IDLE && push |-> push_last)
    else $error("closing result not marked last");
`endif

endmodule

FILE: sv/layered_voice_allocator_release.sv
// ----------------------------------------------------------------------------
// layered_voice_allocator_release
// Voice allocator over a table of voices split into three layers, with
// linear release on sample ticks and termination reports.
//
//   channel  dir  handshake       payload
//   req      in   valid/ready     action, channel, key, tag, layer_sel,
//                                 voice_index
//   rsp      out  valid/ready     kind, voice_id, out_key, out_channel,
//                                 out_tag, last
//   cfg      in   cfg_we_i        cfg_addr_i, cfg_wdata_i
//
// One request at a time. The scan reads one voice table entry per cycle
// while not stalled: a tick or an any-layer note-off reads all LayerVoices*3
// entries, a note-on or layered note-off at most the LayerVoices of one layer,
// a done event one. The single read port of the voice table sets this pace.
// A stalled result channel halts the scan whenever a further result, or the
// closing one, is due while the result register still holds a result.
// Reset clears the valid bit of every entry at once; no clearing pass.
// ----------------------------------------------------------------------------
module layered_voice_allocator_release
  import lva_pkg::*;
#(
  parameter int LayerVoices = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_addr_i,
  input  logic [STEP_W-1:0] cfg_wdata_i,
  lva_req_if.sink           req,
  lva_rsp_if.source         rsp
);

  localparam int NumVoices = LayerVoices * LAYER_COUNT;

  logic              midi_ref_q;
  logic [STEP_W-1:0] rel_step_q;
  cfg_t              cfg;
  ram_req_t          ram_req;
  ram_rsp_t          ram_rsp;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      midi_ref_q <= 1'b0;
      rel_step_q <= RELEASE_STEP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_MIDI_LAYER:   midi_ref_q <= cfg_wdata_i[0];
        CFG_RELEASE_STEP: rel_step_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg.midi_ref = midi_ref_q;
  assign cfg.rel_step = rel_step_q;

  // Scan sequencer.
  lva_engine #(
    .NumVoices (NumVoices)
  ) u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .req       (req),
    .rsp       (rsp),
    .ram_req_o (ram_req),
    .ram_rsp_i (ram_rsp)
  );

  // Voice table.
  lva_voice_ram #(
    .NumVoices (NumVoices)
  ) u_voice_ram (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ram_req),
    .rsp_o  (ram_rsp)
  );

endmodule
